@@ rtl/core/multilevel_queue_dispatcher_unit_defines.svh @@
// assertion macros for the multilevel queue dispatcher
`ifndef MULTILEVEL_QUEUE_DISPATCHER_UNIT_DEFINES_SVH
`define MULTILEVEL_QUEUE_DISPATCHER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MQD_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MQD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/mqd_pkg.sv @@
// types and constants shared by the multilevel queue dispatcher
package mqd_pkg;

  localparam int NUM_LEVELS    = 3;
  localparam logic [15:0] QUANTUM_RESET = 16'd5;

  typedef enum logic [1:0] {
    LVL_FCFS = 2'd0,
    LVL_SJF  = 2'd1,
    LVL_RR   = 2'd2,
    LVL_NONE = 2'd3
  } level_t;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_SLICE    = 2'd2,
    ST_IDLE     = 2'd3
  } status_t;

  typedef enum logic {
    REQ_ENQUEUE  = 1'b0,
    REQ_DISPATCH = 1'b1
  } req_type_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] burst;
  } task_entry_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  served_id;
    logic [15:0] slice_length;
    logic [1:0]  served_level;
    logic        completed;
  } result_t;

endpackage

@@ rtl/core/mqd_ifaces.sv @@
// request, result and quantum write channels
interface mqd_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [7:0]  task_id;
  logic [15:0] burst;
  logic [1:0]  level;

  modport source (output valid, req_type, task_id, burst, level, input ready);
  modport sink (input valid, req_type, task_id, burst, level, output ready);
endinterface

interface mqd_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  served_id;
  logic [15:0] slice_length;
  logic [1:0]  served_level;
  logic        completed;

  modport source (output valid, status, served_id, slice_length, served_level, completed,
                  input ready);
  modport sink (input valid, status, served_id, slice_length, served_level, completed,
                output ready);
endinterface

interface mqd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] quantum;

  modport source (output valid, quantum, input ready);
  modport sink (input valid, quantum, output ready);
endinterface

@@ rtl/core/multilevel_queue_dispatcher_unit.sv @@
// multilevel queue dispatcher: top level
//
//   channel  dir  words carried
//   req      in   req_type, task_id, burst, level
//   res      out  status, served_id, slice_length, served_level, completed
//   cfg      in   quantum (always ready)
//
// enqueue and idle dispatch go from accept to the pending word, then to the result register
// level 0 and level 2 dispatch: head read, finish, result
// level 1 dispatch scans every queued word, one word a cycle through the store
// read port, then finishes and registers the result
// a new request is taken while the previous result still waits on res
// synchronous reset empties all three queues and sets the quantum to 5
module multilevel_queue_dispatcher_unit #(
  parameter int QUEUE_DEPTH = 64
) (
  input logic       clk,
  input logic       rst,
  mqd_req_if.sink   req,
  mqd_res_if.source res,
  mqd_cfg_if.sink   cfg
);

  localparam int ROWS = mqd_pkg::NUM_LEVELS * QUEUE_DEPTH;
  localparam int AW = $clog2(ROWS);

  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  mqd_pkg::task_entry_t mem_wdata, mem_rdata;

  mqd_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .res      (res),
    .cfg      (cfg),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re   (mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  mqd_store #(
    .ROWS(ROWS)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule

@@ rtl/core/mqd_store.sv @@
// task store: one write port, one registered read port
module mqd_store #(
  parameter int ROWS = 192,
  localparam int AW = $clog2(ROWS)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  mqd_pkg::task_entry_t wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output mqd_pkg::task_entry_t rdata
);

  mqd_pkg::task_entry_t mem [ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/mqd_ctrl.sv @@
// dispatch sequencer: queue pointers, head scan, result register
`include "multilevel_queue_dispatcher_unit_defines.svh"

module mqd_ctrl #(
  parameter int QUEUE_DEPTH = 64,
  localparam int ROWS = mqd_pkg::NUM_LEVELS * QUEUE_DEPTH,
  localparam int AW = $clog2(ROWS)
) (
  input  logic                 clk,
  input  logic                 rst,
  mqd_req_if.sink              req,
  mqd_res_if.source            res,
  mqd_cfg_if.sink              cfg,
  output logic                 mem_we,
  output logic [AW-1:0]        mem_waddr,
  output mqd_pkg::task_entry_t mem_wdata,
  output logic                 mem_re,
  output logic [AW-1:0]        mem_raddr,
  input  mqd_pkg::task_entry_t mem_rdata
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_FIN  = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  state_t                 state, state_next;
  logic [PW-1:0]          heads  [mqd_pkg::NUM_LEVELS];
  logic [CW-1:0]          counts [mqd_pkg::NUM_LEVELS];
  logic [15:0]            quantum;
  logic [1:0]             sel_lvl;
  logic [PW-1:0]          rd_pos;
  logic [CW-1:0]          rd_left;
  logic                   rdv, rdl, first;
  logic [PW-1:0]          rdp;
  mqd_pkg::task_entry_t   head_entry, best;
  logic [PW-1:0]          best_pos;
  mqd_pkg::result_t       pend, outr;
  logic                   out_valid;

  logic                   in_acc;
  logic                   lvl_ok;
  logic [1:0]             in_idx;
  logic [1:0]             disp_lvl;
  logic                   any_task;
  logic [15:0]            q_eff, slice_rr, rem_rr;

  function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] h, input logic [CW-1:0] c);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(c);
    if (s >= SW'(QUEUE_DEPTH)) begin
      s = s - SW'(QUEUE_DEPTH);
    end
    return s[PW-1:0];
  endfunction

  function automatic logic [PW-1:0] ring_inc(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [AW-1:0] row_addr(input logic [1:0] l, input logic [PW-1:0] p);
    logic [AW-1:0] base;
    unique case (l)
      mqd_pkg::LVL_SJF: base = AW'(QUEUE_DEPTH);
      mqd_pkg::LVL_RR:  base = AW'(2 * QUEUE_DEPTH);
      default:          base = '0;
    endcase
    return base + AW'(p);
  endfunction

  assign in_acc  = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign lvl_ok  = (req.level != mqd_pkg::LVL_NONE);
  assign in_idx  = lvl_ok ? req.level : 2'd0;
  assign any_task = (counts[0] != '0) || (counts[1] != '0) || (counts[2] != '0);

  // lowest non-empty level wins
  always_comb begin
    if (counts[0] != '0) begin
      disp_lvl = mqd_pkg::LVL_FCFS;
    end else if (counts[1] != '0) begin
      disp_lvl = mqd_pkg::LVL_SJF;
    end else begin
      disp_lvl = mqd_pkg::LVL_RR;
    end
  end

  assign q_eff    = (quantum == 16'd0) ? 16'd1 : quantum;
  assign slice_rr = (best.burst < q_eff) ? best.burst : q_eff;
  assign rem_rr   = best.burst - slice_rr;

  // store access
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = row_addr(sel_lvl, rd_pos);
    unique case (state)
      S_IDLE: begin
        if (in_acc && req.req_type == mqd_pkg::REQ_ENQUEUE && lvl_ok &&
            counts[in_idx] != CW'(QUEUE_DEPTH)) begin
          mem_we    = 1'b1;
          mem_waddr = row_addr(in_idx, ring_add(heads[in_idx], counts[in_idx]));
          mem_wdata = '{id: req.task_id, burst: req.burst};
        end
      end
      S_RUN: begin
        mem_re = (rd_left != '0);
      end
      S_FIN: begin
        if (sel_lvl == mqd_pkg::LVL_SJF && best_pos != heads[1]) begin
          // swap: old head takes the slot the minimum came from
          mem_we    = 1'b1;
          mem_waddr = row_addr(sel_lvl, best_pos);
          mem_wdata = head_entry;
        end else if (sel_lvl == mqd_pkg::LVL_RR && rem_rr != 16'd0) begin
          // requeue at the tail; the popped head slot keeps it in range
          mem_we    = 1'b1;
          mem_waddr = row_addr(sel_lvl, ring_add(heads[2], counts[2]));
          mem_wdata = '{id: best.id, burst: rem_rr};
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          state_next = (req.req_type == mqd_pkg::REQ_DISPATCH && any_task) ? S_RUN : S_RESP;
        end
      end
      S_RUN:  if (rdv && rdl) state_next = S_FIN;
      S_FIN:  state_next = S_RESP;
      S_RESP: if (!out_valid || res.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      quantum   <= mqd_pkg::QUANTUM_RESET;
      out_valid <= 1'b0;
      rdv       <= 1'b0;
      for (int l = 0; l < mqd_pkg::NUM_LEVELS; l++) begin
        heads[l]  <= '0;
        counts[l] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        quantum <= cfg.quantum;
      end
      rdv <= (state == S_RUN) && (rd_left != '0);

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (req.req_type == mqd_pkg::REQ_ENQUEUE) begin
              if (lvl_ok && counts[in_idx] != CW'(QUEUE_DEPTH)) begin
                counts[in_idx] <= counts[in_idx] + CW'(1);
                pend <= '{status: mqd_pkg::ST_ENQUEUED, default: '0};
              end else begin
                pend <= '{status: mqd_pkg::ST_DROPPED, default: '0};
              end
            end else if (!any_task) begin
              pend <= '{status: mqd_pkg::ST_IDLE, default: '0};
            end else begin
              sel_lvl <= disp_lvl;
              rd_pos  <= heads[disp_lvl];
              // shortest-first reads every queued word, the others only the head
              rd_left <= (disp_lvl == mqd_pkg::LVL_SJF) ? counts[1] : CW'(1);
              first   <= 1'b1;
            end
          end
        end
        S_RUN: begin
          if (rd_left != '0) begin
            rd_pos  <= ring_inc(rd_pos);
            rd_left <= rd_left - CW'(1);
            rdp     <= rd_pos;
            rdl     <= (rd_left == CW'(1));
          end
          if (rdv) begin
            if (first) begin
              first      <= 1'b0;
              head_entry <= mem_rdata;
              best       <= mem_rdata;
              best_pos   <= rdp;
            end else if (mem_rdata.burst < best.burst) begin
              best     <= mem_rdata;
              best_pos <= rdp;
            end
          end
        end
        S_FIN: begin
          heads[sel_lvl] <= ring_inc(heads[sel_lvl]);
          if (sel_lvl == mqd_pkg::LVL_RR) begin
            if (rem_rr == 16'd0) begin
              counts[sel_lvl] <= counts[sel_lvl] - CW'(1);
            end
            pend <= '{status: mqd_pkg::ST_SLICE, served_id: best.id, slice_length: slice_rr,
                      served_level: sel_lvl, completed: (rem_rr == 16'd0)};
          end else begin
            counts[sel_lvl] <= counts[sel_lvl] - CW'(1);
            pend <= '{status: mqd_pkg::ST_SLICE, served_id: best.id, slice_length: best.burst,
                      served_level: sel_lvl, completed: 1'b1};
          end
        end
        S_RESP: begin
          if (!out_valid || res.ready) begin
            out_valid <= 1'b1;
            outr      <= pend;
          end
        end
        default: ;
      endcase

      if (state != S_RESP && out_valid && res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign res.valid        = out_valid;
  assign res.status       = outr.status;
  assign res.served_id    = outr.served_id;
  assign res.slice_length = outr.slice_length;
  assign res.served_level = outr.served_level;
  assign res.completed    = outr.completed;

  `MQD_ASSERT_HOLDS(a_count_bound, 1'b1, (counts[0] <= CW'(QUEUE_DEPTH)) && (counts[1] <= CW'(QUEUE_DEPTH)) && (counts[2] <= CW'(QUEUE_DEPTH)), "queue count beyond depth")
  `MQD_ASSERT_HOLDS(a_no_rw_overlap, mem_re, !mem_we, "store read and write in one cycle")
  `MQD_ASSERT_HOLDS(a_scan_drained, state == S_FIN, rd_left == '0 && !rdv, "finish with reads in flight")
  `MQD_ASSERT_HOLDS(a_quiet_fields, res.valid && res.status != mqd_pkg::ST_SLICE, res.served_id == 8'd0 && res.slice_length == 16'd0 && res.served_level == 2'd0 && !res.completed, "non-slice word carries data")
  `MQD_ASSERT_NEXT(a_rr_count, state == S_FIN && sel_lvl == mqd_pkg::LVL_RR, counts[2] == $past(counts[2]) || counts[2] == $past(counts[2]) - CW'(1), "round robin count jumped")

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the multilevel queue dispatcher
`timescale 1ns / 100ps

import mqd_pkg::*;

class dispatch_scoreboard #(int DEPTH = 64);
  task_entry_t slots [NUM_LEVELS][DEPTH];
  int unsigned head [NUM_LEVELS];
  int unsigned count [NUM_LEVELS];
  logic [15:0] quantum;
  result_t awaited [$];
  int unsigned errors, checked;
  int unsigned n_enq, n_drop, n_idle, n_slice, n_done, n_requeue;

  function new();
    foreach (head[l]) begin
      head[l] = 0;
      count[l] = 0;
    end
    quantum = QUANTUM_RESET;
  endfunction

  function void set_quantum(logic [15:0] q);
    quantum = q;
  endfunction

  function int unsigned pending();
    return awaited.size();
  endfunction

  function void push_tail(int l, task_entry_t e);
    slots[l][(head[l] + count[l]) % DEPTH] = e;
    count[l]++;
  endfunction

  function task_entry_t pop_head(int l);
    task_entry_t e;
    e = slots[l][head[l]];
    head[l] = (head[l] + 1) % DEPTH;
    count[l]--;
    return e;
  endfunction

  // strict minimum nearest the head wins, then it swaps places with the head
  function void shortest_to_head();
    int unsigned h, best, p;
    task_entry_t t;
    h = head[LVL_SJF];
    best = h;
    for (int unsigned i = 1; i < count[LVL_SJF]; i++) begin
      p = (h + i) % DEPTH;
      if (slots[LVL_SJF][p].burst < slots[LVL_SJF][best].burst) best = p;
    end
    t = slots[LVL_SJF][h];
    slots[LVL_SJF][h] = slots[LVL_SJF][best];
    slots[LVL_SJF][best] = t;
  endfunction

  function void note_request(req_type_t rt, logic [7:0] id, logic [15:0] b, logic [1:0] lv);
    result_t r;
    task_entry_t e;
    logic [15:0] q, rem;
    int l;
    r = '0;
    if (rt == REQ_ENQUEUE) begin
      if (lv == LVL_NONE || count[lv] >= DEPTH) begin
        r.status = ST_DROPPED;
        n_drop++;
      end else begin
        e.id = id;
        e.burst = b;
        push_tail(lv, e);
        r.status = ST_ENQUEUED;
        n_enq++;
      end
    end else begin
      l = 0;
      while (l < NUM_LEVELS && count[l] == 0) l++;
      if (l == NUM_LEVELS) begin
        r.status = ST_IDLE;
        n_idle++;
      end else begin
        if (l == int'(LVL_SJF)) shortest_to_head();
        e = pop_head(l);
        r.status = ST_SLICE;
        r.served_id = e.id;
        r.served_level = 2'(l);
        n_slice++;
        if (l == int'(LVL_RR)) begin
          // a zero quantum still grants one unit
          q = (quantum == 16'd0) ? 16'd1 : quantum;
          r.slice_length = (e.burst < q) ? e.burst : q;
          rem = e.burst - r.slice_length;
          if (rem != 16'd0) begin
            e.burst = rem;
            push_tail(l, e);
            n_requeue++;
          end else begin
            r.completed = 1'b1;
          end
        end else begin
          r.slice_length = e.burst;
          r.completed = 1'b1;
        end
        if (r.completed) n_done++;
      end
    end
    awaited.push_back(r);
  endfunction

  task report_mismatch(string what);
    errors++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  task check_result(result_t got);
    result_t want;
    if (awaited.size() == 0) begin
      report_mismatch($sformatf("result word with none awaited, status %0d", got.status));
      return;
    end
    want = awaited.pop_front();
    checked++;
    if (got.status !== want.status)
      report_mismatch($sformatf("status %0d, wanted %0d", got.status, want.status));
    if (got.served_id !== want.served_id)
      report_mismatch($sformatf("served_id %0d, wanted %0d", got.served_id, want.served_id));
    if (got.slice_length !== want.slice_length)
      report_mismatch($sformatf("slice_length %0d, wanted %0d",
                                got.slice_length, want.slice_length));
    if (got.served_level !== want.served_level)
      report_mismatch($sformatf("served_level %0d, wanted %0d",
                                got.served_level, want.served_level));
    if (got.completed !== want.completed)
      report_mismatch($sformatf("completed %0d, wanted %0d", got.completed, want.completed));
  endtask
endclass

module testbench;
  localparam int QDEPTH = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst;

  mqd_req_if req_ch ();
  mqd_res_if res_ch ();
  mqd_cfg_if cfg_ch ();

  multilevel_queue_dispatcher_unit #(.QUEUE_DEPTH(QDEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  dispatch_scoreboard #(QDEPTH) sb;
  int send_idle_pct = 11;
  int recv_idle_pct = 49;
  int stall_go = 0;
  int n_quanta = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic send_item(input req_type_t rt, input logic [7:0] id, input logic [15:0] b,
                           input logic [1:0] lv);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= rt;
    req_ch.task_id <= id;
    req_ch.burst <= b;
    req_ch.level <= lv;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(rt, id, b, lv);
  endtask

  task automatic send_random(input int enq_pct);
    req_type_t rt;
    logic [7:0] id;
    logic [15:0] b;
    logic [1:0] lv;
    rt = ($urandom_range(99) < enq_pct) ? REQ_ENQUEUE : REQ_DISPATCH;
    id = 8'($urandom);
    case ($urandom_range(7))
      0: b = '0;
      1: b = '1;
      2, 3, 4: b = 16'($urandom_range(1, 24));
      default: b = 16'($urandom);
    endcase
    lv = ($urandom_range(15) == 0) ? LVL_NONE : 2'($urandom_range(2));
    send_item(rt, id, b, lv);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_quantum(input logic [15:0] q);
    cfg_ch.valid <= 1'b1;
    cfg_ch.quantum <= q;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_quantum(q);
    n_quanta++;
    cfg_ch.valid <= 1'b0;
  endtask

  // receiver: random ready, long hold-off on request, result check
  initial begin
    int stall_seen;
    int hold_left;
    result_t got;
    stall_seen = 0;
    hold_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) begin
        got = {res_ch.status, res_ch.served_id, res_ch.slice_length,
               res_ch.served_level, res_ch.completed};
        sb.check_result(got);
      end
      if (stall_go != stall_seen) begin
        stall_seen = stall_go;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d words outstanding", cycles, sb.pending());
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [15:0] q;
    int enq_pct;
    sb = new();
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_ENQUEUE;
    req_ch.task_id = '0;
    req_ch.burst = '0;
    req_ch.level = LVL_FCFS;
    cfg_ch.valid = 1'b0;
    cfg_ch.quantum = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed part, reset quantum of five
    send_item(REQ_DISPATCH, 8'hFF, 16'hFFFF, LVL_NONE);
    send_item(REQ_ENQUEUE, 8'h5A, 16'd100, LVL_NONE);
    send_item(REQ_ENQUEUE, 8'hFF, 16'hFFFF, LVL_FCFS);
    send_item(REQ_ENQUEUE, 8'h00, 16'd0, LVL_FCFS);
    send_item(REQ_ENQUEUE, 8'h10, 16'd7, LVL_SJF);
    send_item(REQ_ENQUEUE, 8'h11, 16'd3, LVL_SJF);
    send_item(REQ_ENQUEUE, 8'h12, 16'd3, LVL_SJF);
    send_item(REQ_ENQUEUE, 8'h13, 16'd9, LVL_SJF);
    send_item(REQ_ENQUEUE, 8'hA5, 16'd12, LVL_RR);
    send_item(REQ_ENQUEUE, 8'h5A, 16'd0, LVL_RR);
    send_item(REQ_ENQUEUE, 8'h3C, 16'd5, LVL_RR);
    // two fcfs, four shortest first with a tie, round robin with requeues, then idle
    repeat (12) send_item(REQ_DISPATCH, 8'($urandom), 16'($urandom), 2'($urandom));

    for (int p = 0; p < 6; p++) begin
      drain();
      case (p / 2)
        0: begin
          send_idle_pct = 11;
          recv_idle_pct = 49;
        end
        1: begin
          send_idle_pct = 49;
          recv_idle_pct = 11;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (p)
        0: q = 16'd1;
        1: q = 16'd0;
        2: q = 16'hFFFF;
        3: q = 16'd3;
        4: q = 16'd2;
        default: q = 16'($urandom_range(1, 65535));
      endcase
      case (p)
        0: enq_pct = 70;
        1: enq_pct = 30;
        2: enq_pct = 90;
        3: enq_pct = 25;
        4: enq_pct = 65;
        default: enq_pct = 35;
      endcase
      write_quantum(q);
      for (int n = 0; n < 250; n++) begin
        // hold results back while requests keep coming, so the block backs up
        if (p == 2 && n == 40) stall_go++;
        send_random(enq_pct);
      end
    end

    drain();
    repeat (80) @(posedge clk);
    $display("covered %0d enqueues, %0d drops, %0d idle answers, %0d slices",
             sb.n_enq, sb.n_drop, sb.n_idle, sb.n_slice);
    $display("%0d slices completed, %0d requeued, %0d quantum settings, %0d words checked",
             sb.n_done, sb.n_requeue, n_quanta, sb.checked);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("FAIL");
    end
    $finish;
  end
endmodule
